// ===== hw/rtl/dr_pkg.sv =====
// ----------------------------------------------------------------------------
// dr_pkg - shared definitions for the digraph reachability block
// Field widths, item kind codes, default graph size and sequencer states.
// ----------------------------------------------------------------------------
package dr_pkg;

  localparam int NUM_VERTICES_DEF = 32;   // default graph size
  localparam int VERTEX_W         = 5;    // width of vertex fields
  localparam int MASK_W           = 32;   // width of neighbor_mask

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

endpackage

// ===== hw/rtl/dr_adj_mem.sv =====
// ----------------------------------------------------------------------------
// dr_adj_mem - adjacency row store
// One row per vertex, one write and one registered read per cycle. A per-row
// valid bit cleared by reset makes never-written rows read as zero.
// ----------------------------------------------------------------------------
module dr_adj_mem
  import dr_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF,
  localparam int AW = $clog2(NUM_VERTICES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [NUM_VERTICES-1:0] wr_row,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [NUM_VERTICES-1:0] rd_row
);

  logic [NUM_VERTICES-1:0] mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] row_valid;
  logic [NUM_VERTICES-1:0] rd_data;
  logic                    rd_data_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid     <= '0;
      rd_data_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_data_valid <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_data_valid ? rd_data : '0;

endmodule

// ===== hw/rtl/dr_expand.sv =====
// ----------------------------------------------------------------------------
// dr_expand - search step
// Merges a returned adjacency row into the visited set and picks the lowest
// visited vertex not yet expanded.
// ----------------------------------------------------------------------------
module dr_expand
  import dr_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF,
  localparam int AW = $clog2(NUM_VERTICES)
) (
  input  logic [NUM_VERTICES-1:0] visited,
  input  logic [NUM_VERTICES-1:0] expanded,
  input  logic                    row_valid,
  input  logic [NUM_VERTICES-1:0] row,
  output logic [NUM_VERTICES-1:0] visited_next,
  output logic                    pick_valid,
  output logic [NUM_VERTICES-1:0] pick_onehot,
  output logic [AW-1:0]           pick_idx
);

  logic [NUM_VERTICES-1:0] cand;

  always_comb begin
    visited_next = visited | (row_valid ? row : '0);
    cand         = visited_next & ~expanded;
    pick_valid   = |cand;
    // isolate lowest set bit
    pick_onehot  = cand & (~cand + NUM_VERTICES'(1));
    pick_idx     = '0;
    for (int i = 0; i < NUM_VERTICES; i++) begin
      if (pick_onehot[i]) begin
        pick_idx = pick_idx | AW'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/digraph_reachability.sv =====
// ----------------------------------------------------------------------------
// digraph_reachability - directed graph reachability engine
// Holds an adjacency bit matrix and answers source-to-target reachability.
// ----------------------------------------------------------------------------
// The graph lives in a row store of NUM_VERTICES rows, all empty after reset.
// A write item (kind = 0) replaces one row and gives no result; bits of
// neighbor_mask at or above NUM_VERTICES are dropped, and a write to a row
// outside the graph is ignored. A query item (kind = 1) gives exactly one
// result: reachable = 1 when target_vertex can be reached from source_vertex
// along edges (a vertex always reaches itself), 0 otherwise or when either
// vertex lies outside the graph. A query walks the graph one adjacency row
// per cycle through the single read port of the row store: each cycle the
// lowest visited-but-unexpanded vertex is read and its row is merged into
// the visited set the cycle after. The walk stops as soon as the target is
// visited or no vertex is left to expand, and the answer then passes through
// ST_RESULT into the output register; a query naming a vertex outside the
// graph skips the walk and goes straight to ST_RESULT. in_ready stays low
// until the result enters the output register, which waits while the
// previous result has not yet been taken; a write leaves in_ready high.
// A result waits in the output register until taken, and the block accepts
// new items while it waits.
// ----------------------------------------------------------------------------
module digraph_reachability
  import dr_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [VERTEX_W-1:0] source_vertex,
  input  logic [VERTEX_W-1:0] target_vertex,
  input  logic [MASK_W-1:0]   neighbor_mask,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                reachable
);

  localparam int AW = $clog2(NUM_VERTICES);

  // sequencer state
  state_t                  state, state_next;
  logic [NUM_VERTICES-1:0] visited, visited_next;
  logic [NUM_VERTICES-1:0] expanded, expanded_next;
  logic                    pending, pending_next;    // row read in flight
  logic [AW-1:0]           target, target_next;
  logic                    res, res_next;
  logic                    out_valid_next;
  logic                    reachable_next;

  // input decode
  logic accept;
  logic src_ok, dst_ok;

  // row store
  logic                    wr_en;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [NUM_VERTICES-1:0] rd_row;

  // search step
  logic [NUM_VERTICES-1:0] step_visited;
  logic                    pick_valid;
  logic [NUM_VERTICES-1:0] pick_onehot;
  logic [AW-1:0]           pick_idx;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign src_ok   = 32'(source_vertex) < 32'(NUM_VERTICES);
  assign dst_ok   = 32'(target_vertex) < 32'(NUM_VERTICES);
  assign wr_en    = accept && (kind == KIND_WRITE) && src_ok;

  dr_adj_mem #(
    .NUM_VERTICES(NUM_VERTICES)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (AW'(source_vertex)),
    .wr_row  (NUM_VERTICES'(neighbor_mask)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row)
  );

  dr_expand #(
    .NUM_VERTICES(NUM_VERTICES)
  ) u_expand (
    .visited      (visited),
    .expanded     (expanded),
    .row_valid    (pending),
    .row          (rd_row),
    .visited_next (step_visited),
    .pick_valid   (pick_valid),
    .pick_onehot  (pick_onehot),
    .pick_idx     (pick_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    visited   <= visited_next;
    expanded  <= expanded_next;
    target    <= target_next;
    res       <= res_next;
    reachable <= reachable_next;
  end

  always_comb begin
    state_next     = state;
    visited_next   = visited;
    expanded_next  = expanded;
    pending_next   = 1'b0;
    target_next    = target;
    res_next       = res;
    out_valid_next = out_valid;
    reachable_next = reachable;
    rd_en          = 1'b0;
    rd_addr        = pick_idx;

    // output register drains independently of the sequencer
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_QUERY)) begin
          if (src_ok && dst_ok) begin
            visited_next  = NUM_VERTICES'(1) << source_vertex;
            expanded_next = '0;
            target_next   = AW'(target_vertex);
            state_next    = ST_SEARCH;
          end else begin
            res_next   = 1'b0;
            state_next = ST_RESULT;
          end
        end
      end

      ST_SEARCH: begin
        visited_next = step_visited;
        if (step_visited[target]) begin
          res_next   = 1'b1;
          state_next = ST_RESULT;
        end else if (!pick_valid) begin
          // nothing left to expand and no read in flight
          res_next   = 1'b0;
          state_next = ST_RESULT;
        end else begin
          rd_en         = 1'b1;
          expanded_next = expanded | pick_onehot;
          pending_next  = 1'b1;
        end
      end

      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          reachable_next = res;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dr_checker.sv =====
// ----------------------------------------------------------------------------
// dr_checker - port-level checks for digraph_reachability
// Watches the handshakes and the item flow seen at the top-level ports.
// ----------------------------------------------------------------------------
module dr_checker
  import dr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic kind,
  input logic out_valid,
  input logic out_ready,
  input logic reachable
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reachable))
    else $error("result changed or dropped while stalled");

  // a write item never raises a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_WRITE) && !out_valid |=> !out_valid)
    else $error("write item produced a result");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_QUERY) |=> !in_ready)
    else $error("input ready right after a query");

  // a new result comes only as the search finishes
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result offered while search still busy");

endmodule

bind digraph_reachability dr_checker u_dr_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for digraph_reachability
// Drives row writes and reachability queries under random handshake idling.
// Every result is checked against a typed-in answer or a reachability predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import dr_pkg::*;

  localparam int NV        = NUM_VERTICES_DEF;
  localparam int ITEM_GOAL = 550;  // directed plus random items
  localparam int QUIET_AT  = 490;  // from here on neither side idles
  localparam int N_DIR     = 23;   // rows in the directed table
  // Tail wait covering the longest query plus a waiting result on top.
  localparam int TAIL_CYC  = NV + 16;
  localparam logic [MASK_W-1:0] GRAPH_BITS = (NV >= MASK_W) ? '1 : ((1 << NV) - 1);

  // One directed stimulus row. fixed_f marks rows whose answer is typed in.
  typedef struct packed {
    logic                kind_f;
    logic [VERTEX_W-1:0] src_f;
    logic [VERTEX_W-1:0] dst_f;
    logic [MASK_W-1:0]   mask_f;
    logic                fixed_f;
    logic                answer_f;
  } graph_step_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                kind = KIND_WRITE;
  logic [VERTEX_W-1:0] source_vertex = '0;
  logic [VERTEX_W-1:0] target_vertex = '0;
  logic [MASK_W-1:0]   neighbor_mask = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                reachable;

  digraph_reachability DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .source_vertex (source_vertex),
    .target_vertex (target_vertex),
    .neighbor_mask (neighbor_mask),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reachable     (reachable)
  );

  // Bench-side copy of the graph and answers still owed by the block,
  // oldest first.
  logic [MASK_W-1:0] adj_rows [0:(1 << VERTEX_W)-1];
  bit                reach_due [$];
  graph_step_t       steps [0:N_DIR-1];

  int items_sent   = 0;
  int writes_sent  = 0;
  int queries_sent = 0;
  int hits_seen    = 0;
  int misses_seen  = 0;
  int fail_cnt     = 0;
  int gap_pct      = 25;    // chance in percent of a gap before an item
  bit quiet        = 1'b0;  // end of run: no idling on either side
  int stall_left   = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("%0t: run timed out with %0d results outstanding", $time, reach_due.size());
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // A write replaces the row; mask bits beyond the graph are dropped and a
  // row outside the graph is left alone.
  function automatic void store_row(logic [VERTEX_W-1:0] src, logic [MASK_W-1:0] mask);
    if (src < NV)
      adj_rows[src] = mask & GRAPH_BITS;
  endfunction

  // Grow the visited set one frontier at a time from the source. A vertex
  // reaches itself, so the source starts out visited.
  function automatic bit reach_of(logic [VERTEX_W-1:0] src, logic [VERTEX_W-1:0] dst);
    logic [MASK_W-1:0] seen;
    logic [MASK_W-1:0] front;
    logic [MASK_W-1:0] grown;
    int                rounds;
    int                i;
    if (src >= NV || dst >= NV)
      return 1'b0;
    seen   = '0;
    seen[src] = 1'b1;
    front  = seen;
    rounds = 0;
    while (rounds < NV && front != '0 && !seen[dst]) begin
      grown = '0;
      for (i = 0; i < NV; i++)
        if (front[i])
          grown |= adj_rows[i];
      grown &= GRAPH_BITS;
      front  = grown & ~seen;
      seen  |= grown;
      rounds++;
    end
    return seen[dst];
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional gap, then hold the item until in_valid && in_ready.
  // The prediction is taken at acceptance, so it sees exactly the rows the
  // block had when the item went in.
  // --------------------------------------------------------------------------
  task automatic send(input logic k, input logic [VERTEX_W-1:0] s,
                      input logic [VERTEX_W-1:0] t, input logic [MASK_W-1:0] m,
                      input bit fixed, input bit answer);
    int gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    source_vertex <= s;
    target_vertex <= t;
    neighbor_mask <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (k == KIND_WRITE) begin
      store_row(s, m);
      writes_sent++;
    end else begin
      reach_due.push_back(fixed ? answer : reach_of(s, t));
      queries_sent++;
    end
    if (items_sent >= QUIET_AT)
      quiet = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: out_ready drops in bursts of random length, never once quiet.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: each taken result against the oldest owed answer.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reach_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got reachable=%0b",
                 $time, reachable);
        fail_cnt++;
      end else begin
        if (reachable !== reach_due[0]) begin
          $display("%0t: reachable mismatch, expected %0b, got %0b",
                   $time, reach_due[0], reachable);
          fail_cnt++;
        end
        if (reach_due[0])
          hits_seen++;
        else
          misses_seen++;
        void'(reach_due.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic [VERTEX_W-1:0] order [0:31];
    logic [VERTEX_W-1:0] tmp;
    logic [VERTEX_W-1:0] s;
    logic [VERTEX_W-1:0] t;
    logic [MASK_W-1:0]   row;
    int                  i;
    int                  j;
    int                  len;
    int                  nq;
    int                  waited;

    // Directed table. With 5-bit vertex fields and a 32-vertex graph no
    // vertex or mask bit can fall outside the graph, so those cases do not
    // arise. Some queries carry junk in neighbor_mask to show it is ignored.
    //                kind        src     dst     mask          fixed answer
    steps[0]  = '{KIND_QUERY, 5'd0,  5'd0,  32'hA5A5_5A5A, 1'b1, 1'b1}; // self, empty graph
    steps[1]  = '{KIND_QUERY, 5'd0,  5'd31, 32'hFFFF_FFFF, 1'b1, 1'b0}; // empty graph
    steps[2]  = '{KIND_QUERY, 5'd31, 5'd0,  32'h0000_0000, 1'b1, 1'b0};
    steps[3]  = '{KIND_WRITE, 5'd0,  5'd31, 32'hFFFF_FFFF, 1'b0, 1'b0}; // full row
    steps[4]  = '{KIND_QUERY, 5'd0,  5'd31, 32'h0000_0000, 1'b1, 1'b1};
    steps[5]  = '{KIND_QUERY, 5'd0,  5'd0,  32'h0000_0000, 1'b1, 1'b1};
    steps[6]  = '{KIND_QUERY, 5'd5,  5'd0,  32'h0000_0000, 1'b1, 1'b0}; // edges are one-way
    steps[7]  = '{KIND_WRITE, 5'd31, 5'd0,  32'h0000_0001, 1'b0, 1'b0}; // 31 -> 0
    steps[8]  = '{KIND_QUERY, 5'd31, 5'd17, 32'h0000_0000, 1'b1, 1'b1}; // via vertex 0
    steps[9]  = '{KIND_WRITE, 5'd0,  5'd0,  32'h0000_0000, 1'b0, 1'b0}; // clear row 0
    steps[10] = '{KIND_QUERY, 5'd31, 5'd17, 32'h0000_0000, 1'b1, 1'b0};
    steps[11] = '{KIND_QUERY, 5'd31, 5'd0,  32'h0000_0000, 1'b1, 1'b1};
    steps[12] = '{KIND_WRITE, 5'd7,  5'd1,  32'h0000_0080, 1'b0, 1'b0}; // self edge only
    steps[13] = '{KIND_QUERY, 5'd7,  5'd7,  32'h0000_0000, 1'b1, 1'b1};
    steps[14] = '{KIND_QUERY, 5'd7,  5'd8,  32'h0000_0000, 1'b1, 1'b0};
    steps[15] = '{KIND_WRITE, 5'd2,  5'd0,  32'h0000_0008, 1'b0, 1'b0}; // 2 -> 3
    steps[16] = '{KIND_WRITE, 5'd3,  5'd0,  32'h0000_0004, 1'b0, 1'b0}; // 3 -> 2, closed loop
    steps[17] = '{KIND_QUERY, 5'd2,  5'd9,  32'h0000_0000, 1'b1, 1'b0}; // loop must end
    steps[18] = '{KIND_WRITE, 5'd3,  5'd0,  32'h8000_0004, 1'b0, 1'b0}; // loop exit to 31
    steps[19] = '{KIND_QUERY, 5'd2,  5'd0,  32'h0000_0000, 1'b0, 1'b0};
    steps[20] = '{KIND_QUERY, 5'd0,  5'd2,  32'h0000_0000, 1'b0, 1'b0};
    steps[21] = '{KIND_WRITE, 5'd31, 5'd0,  32'h0000_0000, 1'b0, 1'b0};
    steps[22] = '{KIND_QUERY, 5'd2,  5'd0,  32'h0000_0000, 1'b0, 1'b0};

    for (i = 0; i < (1 << VERTEX_W); i++)
      adj_rows[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIR; i++)
      send(steps[i].kind_f, steps[i].src_f, steps[i].dst_f, steps[i].mask_f,
           steps[i].fixed_f, steps[i].answer_f);

    // Random part, in episodes. Most episodes build a well-formed graph
    // (long paths, sparse rows) and then query it; others clear rows or send noise.
    while (items_sent < ITEM_GOAL) begin
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      case ($urandom_range(0, 4))
        0, 1: begin
          // Path through a shuffled vertex order. Extra edges only point
          // back along the path, so the search depth stays the path length.
          len = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(2, 12);
          for (i = 0; i < 32; i++)
            order[i] = i[VERTEX_W-1:0];
          for (i = 31; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          for (i = 0; i < len; i++) begin
            row = (i < len - 1) ? (32'b1 << order[i + 1]) : '0;
            if ($urandom_range(0, 3) == 0)
              row |= 32'b1 << order[$urandom_range(0, i)];
            send(KIND_WRITE, order[i], VERTEX_W'($urandom_range(0, 31)), row,
                 1'b0, 1'b0);
          end
          nq = $urandom_range(3, 8);
          for (i = 0; i < nq; i++) begin
            case ($urandom_range(0, 2))
              0: begin
                s = order[0];
                t = order[len - 1];
              end
              1: begin
                s = order[$urandom_range(0, len - 1)];
                t = order[$urandom_range(0, len - 1)];
              end
              default: begin
                s = VERTEX_W'($urandom_range(0, 31));
                t = VERTEX_W'($urandom_range(0, 31));
              end
            endcase
            send(KIND_QUERY, s, t, $urandom, 1'b0, 1'b0);
          end
        end
        2: begin
          // Sparse graph: rows with one or two neighbor bits set, then queries.
          nq = $urandom_range(4, 12);
          for (i = 0; i < nq; i++) begin
            row = 32'b1 << $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1)
              row |= 32'b1 << $urandom_range(0, 31);
            send(KIND_WRITE, VERTEX_W'($urandom_range(0, 31)),
                 VERTEX_W'($urandom_range(0, 31)), row, 1'b0, 1'b0);
          end
          nq = $urandom_range(4, 10);
          for (i = 0; i < nq; i++)
            send(KIND_QUERY, VERTEX_W'($urandom_range(0, 31)),
                 VERTEX_W'($urandom_range(0, 31)), $urandom, 1'b0, 1'b0);
        end
        3: begin
          // Clear some rows so unreachable answers stay common.
          nq = $urandom_range(4, 16);
          for (i = 0; i < nq; i++)
            send(KIND_WRITE, VERTEX_W'($urandom_range(0, 31)),
                 VERTEX_W'($urandom_range(0, 31)), '0, 1'b0, 1'b0);
          nq = $urandom_range(3, 8);
          for (i = 0; i < nq; i++)
            send(KIND_QUERY, VERTEX_W'($urandom_range(0, 31)),
                 VERTEX_W'($urandom_range(0, 31)), $urandom, 1'b0, 1'b0);
        end
        default: begin
          // Noise: any kind, any fields, full random masks.
          nq = $urandom_range(5, 15);
          for (i = 0; i < nq; i++)
            send(1'($urandom_range(0, 1)), VERTEX_W'($urandom_range(0, 31)),
                 VERTEX_W'($urandom_range(0, 31)), $urandom, 1'b0, 1'b0);
        end
      endcase
    end

    in_valid <= 1'b0;

    // Drain: wait for every owed answer, then watch a while for strays.
    waited = 0;
    while (reach_due.size() != 0 && waited < 20 * TAIL_CYC) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYC) @(posedge clk);
    if (reach_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, reach_due.size());
      fail_cnt++;
    end

    $display("Sent %0d items: %0d row writes and %0d queries.",
             items_sent, writes_sent, queries_sent);
    $display("Checked %0d reachable and %0d unreachable answers.",
             hits_seen, misses_seen);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
